@@ hw/rtl/asbn_pkg.sv @@
// Shared types, constants and reply text for the addressed serial bus node.
package asbn_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [15:0] BIT_PERIOD_RESET = 16'd100;
    localparam logic [7:0]  NODE_ADDR_RESET  = 8'd48;

    // APB register indexes
    localparam logic REG_BIT_PERIOD = 1'b0;
    localparam logic REG_NODE_ADDR  = 1'b1;

    // tx bit slots within one byte frame
    localparam logic [3:0] TX_SLOT_START = 4'd0;
    localparam logic [3:0] TX_SLOT_LAST_DATA = 4'd8;
    localparam logic [3:0] TX_SLOT_LAST = 4'd10;

    localparam logic [2:0] TX_ECHO_BYTE = 3'd6;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_HALF = 2'd1,
        RX_DATA = 2'd2,
        RX_STOP = 2'd3
    } rx_phase_t;

    // what the receiver reports for one tick
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [7:0] data;
    } rx_stat_t;

    // reply: "node ", a zero byte, the received byte, newline
    function automatic logic [7:0] reply_char(input logic [2:0] idx, input logic [7:0] echo);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6E;
            3'd1:    c = 8'h6F;
            3'd2:    c = 8'h64;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h20;
            3'd5:    c = 8'h00;
            3'd6:    c = echo;
            default: c = 8'h0A;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/asbn_rx.sv @@
// Receiver: start detect, mid-bit sampling, stop wait and address match.
module asbn_rx #(
    parameter int COUNT_WIDTH = asbn_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   hold,
    input  logic                   rx_level,
    input  logic [COUNT_WIDTH-1:0] period,
    input  logic [COUNT_WIDTH-1:0] half_period,
    input  logic [7:0]             node_address,
    output asbn_pkg::rx_stat_t     stat
);

    asbn_pkg::rx_phase_t    phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] wait_len;
    logic                   wait_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= asbn_pkg::RX_IDLE;
            count_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

    // saturating tick counter shared by all waits
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign wait_len  = (phase_reg == asbn_pkg::RX_HALF) ? half_period : period;
    assign wait_done = (count_inc >= wait_len);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        stat.valid = 1'b0;
        stat.hit   = 1'b0;
        if (!hold) begin
            case (phase_reg)
                asbn_pkg::RX_IDLE: begin
                    if (!rx_level) begin
                        phase_next = asbn_pkg::RX_HALF;
                        count_next = '0;
                        bit_next   = '0;
                        shift_next = '0;
                    end
                end
                asbn_pkg::RX_HALF: begin
                    count_next = wait_done ? '0 : count_inc;
                    if (wait_done) begin
                        // bit number zero: before data, otherwise after stop
                        if (bit_reg == 3'd0) begin
                            phase_next = asbn_pkg::RX_DATA;
                        end else begin
                            bit_next   = '0;
                            phase_next = asbn_pkg::RX_IDLE;
                            stat.valid = 1'b1;
                            stat.hit   = (shift_reg == node_address);
                        end
                    end
                end
                asbn_pkg::RX_DATA: begin
                    count_next = wait_done ? '0 : count_inc;
                    if (wait_done) begin
                        shift_next = shift_reg | (8'(rx_level) << bit_reg);
                        bit_next   = bit_reg + 3'd1;
                        if (bit_reg == 3'd7) begin
                            phase_next = asbn_pkg::RX_STOP;
                        end
                    end
                end
                default: begin
                    count_next = wait_done ? '0 : count_inc;
                    if (wait_done) begin
                        bit_next   = 3'd1;
                        phase_next = asbn_pkg::RX_HALF;
                    end
                end
            endcase
        end
        stat.data = shift_next;
    end

endmodule

@@ hw/rtl/asbn_tx.sv @@
// Transmitter: sends the eight-byte reply once the node is addressed.
module asbn_tx #(
    parameter int COUNT_WIDTH = asbn_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] period,
    input  logic [7:0]             echo_byte,
    output logic                   tx_line,
    output logic                   tx_enable
);

    logic                   busy_reg, busy_next;
    logic [2:0]             byte_reg, byte_next;
    logic [3:0]             slot_reg, slot_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [7:0]             cur_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            byte_reg  <= '0;
            slot_reg  <= '0;
            count_reg <= '0;
        end else if (advance) begin
            busy_reg  <= busy_next;
            byte_reg  <= byte_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
        end
    end

    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign cur_byte  = asbn_pkg::reply_char(byte_reg, echo_byte);
    assign tx_enable = busy_reg;

    always_comb begin
        busy_next  = busy_reg;
        byte_next  = byte_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        tx_line    = 1'b1;
        if (busy_reg) begin
            if (slot_reg == asbn_pkg::TX_SLOT_START) begin
                tx_line = 1'b0;
            end else if (slot_reg <= asbn_pkg::TX_SLOT_LAST_DATA) begin
                tx_line = cur_byte[3'(slot_reg - 4'd1)];
            end
            if (count_inc >= period) begin
                count_next = '0;
                if (slot_reg == asbn_pkg::TX_SLOT_LAST) begin
                    slot_next = '0;
                    byte_next = byte_reg + 3'd1;
                    if (byte_reg == 3'd7) begin
                        busy_next = 1'b0;
                    end
                end else begin
                    slot_next = slot_reg + 4'd1;
                end
            end else begin
                count_next = count_inc;
            end
        end else if (start) begin
            busy_next  = 1'b1;
            byte_next  = '0;
            slot_next  = '0;
            count_next = '0;
        end
    end

endmodule

@@ hw/rtl/addressed_serial_bus_node_core.sv @@
// Top level of the addressed serial bus node: stream ports, APB registers, output stage.
// Every input item is one clock tick of the sampled receive line; every item yields exactly
// one result item, registered, so it appears on the m_ side in the cycle after acceptance.
// One item is taken per clock unless the input stalls: the receiver and transmitter state
// advance once per accepted item through a single pass of counter compare and shift logic.
// The input is ready while the output register is empty or its result is taken in the same
// cycle, so a result left waiting stalls the input. Received frames are 8N1: the first data
// bit is sampled period/2 + period ticks after the start tick (about 1.5 bit periods), the
// others once per period; a byte equal to node_address starts, on the next tick, an
// eight-byte reply ("node ", 0x00, the byte, 0x0A) of 11 bit periods per byte, during which
// reception is ignored. The bit period is bit_period_reg clamped to 1..2**COUNT_WIDTH-1.
module addressed_serial_bus_node_core #(
    parameter int COUNT_WIDTH = asbn_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [0] rx_level, [7:1] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: [0] tx_line, [1] tx_enable, [2] rx_valid, [10:3] rx_byte, [11] addressed,
    // [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [15:0] bit_period_reg;
    logic [7:0]  node_addr_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   cfg_wr;
    logic [PW-1:0]          bpt_ext, cmax_ext, p_sel;
    logic [COUNT_WIDTH-1:0] period, half_raw, half_period;
    asbn_pkg::rx_stat_t     rx_stat;
    logic                   tx_line, tx_enable;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= asbn_pkg::BIT_PERIOD_RESET;
            node_addr_reg  <= asbn_pkg::NODE_ADDR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == asbn_pkg::REG_BIT_PERIOD) begin
                bit_period_reg <= pwdata[15:0];
            end else begin
                node_addr_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            asbn_pkg::REG_BIT_PERIOD: prdata = {16'd0, bit_period_reg};
            asbn_pkg::REG_NODE_ADDR:  prdata = {24'd0, node_addr_reg};
            default:                  prdata = '0;
        endcase
    end

    // period clamped to the counter range, zero acts as one
    assign bpt_ext     = PW'(bit_period_reg);
    assign cmax_ext    = PW'({COUNT_WIDTH{1'b1}});
    assign p_sel       = (bpt_ext > cmax_ext) ? cmax_ext : bpt_ext;
    assign period      = (p_sel == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(p_sel);
    assign half_raw    = period >> 1;
    assign half_period = (half_raw == '0) ? COUNT_WIDTH'(1) : half_raw;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    asbn_rx #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .hold        (tx_enable),
        .rx_level    (s_tdata[0]),
        .period      (period),
        .half_period (half_period),
        .node_address(node_addr_reg),
        .stat        (rx_stat)
    );

    asbn_tx #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (accept),
        .start    (rx_stat.hit),
        .period   (period),
        .echo_byte(rx_stat.data),
        .tx_line  (tx_line),
        .tx_enable(tx_enable)
    );

    assign m_tdata_next = {4'd0, rx_stat.hit, rx_stat.data, rx_stat.valid, tx_enable, tx_line};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
